// File: sv/tpsu_pkg.sv
// ----------------------------------------------------------------------------
// tpsu_pkg
// Types and constants shared by the triangle plane slice unit.
// ----------------------------------------------------------------------------
package tpsu_pkg;

   localparam int unsigned LamBits     = 16;
   localparam int unsigned OutAddrBits = 5;   // result queue, must exceed back latency

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by_coord;
      logic signed [31:0] bz;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] plane_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } rsp_type;

   // one edge crossing job: origin, span and ratio operands
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]        num;
      logic [32:0]        den;
      logic               sat;
      logic               zero;
   } edge_type;

   typedef struct packed {
      logic     cand;
      edge_type e0;
      edge_type e1;
   } work_type;

endpackage

// File: sv/triangle_plane_slice_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_slice_unit
// Cuts a triangle with a horizontal plane and returns the xy segment.
// ----------------------------------------------------------------------------
// path: front register, mid queue, 16-stage divider, multiply register, result queue
// throughput: one request per cycle unless credits or a full mid queue stall it
// results are held in a 32-entry queue; issue to the back end is credit based
// reset: synchronous, empties all queues and pipeline valids
module triangle_plane_slice_unit #(
   parameter int unsigned MID_ADDR_BITS = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  tpsu_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tpsu_pkg::rsp_type rsp_data
);
   import tpsu_pkg::*;

   localparam int unsigned OutDepth = 1 << OutAddrBits;

   logic     front_ready, front_valid, mid_full, mid_empty, issue;
   work_type front_data, mid_data;
   logic     back_valid;
   rsp_type  back_data;
   logic [OutAddrBits:0] credit_ff, credit_in;
   logic     out_full_unused;

   assign req_full = !front_ready;

   tpsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_push),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .out_valid (front_valid),
      .out_data  (front_data),
      .out_full  (mid_full)
   );

   tpsu_fifo #(.WIDTH($bits(work_type)), .ADDR_BITS(MID_ADDR_BITS)) u_mid (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .full      (mid_full),
      .pop       (issue),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   // count of requests in the back end plus waiting results
   assign issue = !mid_empty && (credit_ff != (OutAddrBits+1)'(OutDepth));

   always_comb begin
      credit_in = credit_ff + (OutAddrBits+1)'(issue)
                - (OutAddrBits+1)'(rsp_pop && !rsp_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   tpsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_data   (mid_data),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   tpsu_fifo #(.WIDTH($bits(rsp_type)), .ADDR_BITS(OutAddrBits)) u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_data),
      .full      (out_full_unused),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   logic unused_ok;
   assign unused_ok = out_full_unused;
endmodule

// File: sv/tpsu_fifo.sv
// ----------------------------------------------------------------------------
// tpsu_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tpsu_fifo #(
   parameter int unsigned WIDTH     = 8,
   parameter int unsigned ADDR_BITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned Depth = 1 << ADDR_BITS;

   logic [WIDTH-1:0]   mem_ff [Depth];
   logic [ADDR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ADDR_BITS:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full     = (cnt_ff == (ADDR_BITS+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ADDR_BITS+1)'(do_push) - (ADDR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// File: sv/tpsu_front.sv
// ----------------------------------------------------------------------------
// tpsu_front
// Classifies vertices against the plane and sets up the edge crossing jobs e0 and e1.
// ----------------------------------------------------------------------------
module tpsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tpsu_pkg::req_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output tpsu_pkg::work_type out_data,
   input  logic              out_full
);
   import tpsu_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vtx_type;

   function automatic edge_type make_edge(vtx_type p, vtx_type q, logic signed [31:0] h);
      edge_type          e;
      logic signed [32:0] n, d;
      e.px   = p.x;
      e.py   = p.y;
      e.dx   = 33'(q.x) - 33'(p.x);
      e.dy   = 33'(q.y) - 33'(p.y);
      n      = 33'(h) - 33'(p.z);
      d      = 33'(q.z) - 33'(p.z);
      e.num  = n[32] ? 33'(-n) : n;
      e.den  = d[32] ? 33'(-d) : d;
      e.zero = (e.den == '0);
      e.sat  = !e.zero && (e.num >= e.den);
      return e;
   endfunction

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   vtx_type  v [3];
   logic [2:0] pos, neg;
   logic     accept;
   vtx_type  lone, e1, e2;
   logic     on_plane;
   logic signed [32:0] dz [3];

   assign in_ready  = !valid_ff || !out_full;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      v[0] = '{x: in_data.ax, y: in_data.ay,       z: in_data.az};
      v[1] = '{x: in_data.bx, y: in_data.by_coord, z: in_data.bz};
      v[2] = '{x: in_data.cx, y: in_data.cy,       z: in_data.cz};
      for (int i = 0; i < 3; i++) begin
         dz[i]  = 33'(v[i].z) - 33'(in_data.plane_z);
         neg[i] = dz[i][32];
         pos[i] = !dz[i][32] && (dz[i] != '0);
      end
      on_plane = 1'b0;
      priority if ((pos[0] && pos[1]) || (neg[0] && neg[1])) begin
         lone = v[2]; e1 = v[0]; e2 = v[1];
      end else if ((pos[1] && pos[2]) || (neg[1] && neg[2])) begin
         lone = v[0]; e1 = v[1]; e2 = v[2];
      end else if ((pos[0] && pos[2]) || (neg[0] && neg[2])) begin
         lone = v[1]; e1 = v[0]; e2 = v[2];
      end else begin
         on_plane = 1'b1;
         priority if (!pos[0] && !neg[0]) begin
            lone = v[0]; e1 = v[1]; e2 = v[2];
         end else if (!pos[1] && !neg[1]) begin
            lone = v[1]; e1 = v[0]; e2 = v[2];
         end else begin
            lone = v[2]; e1 = v[1]; e2 = v[0];
         end
      end
      data_in.cand = !((neg == 3'b000) || (pos == 3'b000));
      if (on_plane) begin
         // zero-height edge from the on-plane vertex yields the vertex itself
         data_in.e0 = make_edge(lone, lone, in_data.plane_z);
         data_in.e1 = make_edge(e1, e2, in_data.plane_z);
      end else begin
         data_in.e0 = make_edge(lone, e1, in_data.plane_z);
         data_in.e1 = make_edge(lone, e2, in_data.plane_z);
      end
      valid_in = accept ? 1'b1 : (valid_ff && out_full);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end
endmodule

// File: sv/tpsu_back.sv
// ----------------------------------------------------------------------------
// tpsu_back
// Pipelined ratio divider, interpolation multiply and segment check.
// ----------------------------------------------------------------------------
module tpsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tpsu_pkg::work_type in_data,
   output logic               out_valid,
   output tpsu_pkg::rsp_type  out_data
);
   import tpsu_pkg::*;

   typedef struct packed {
      work_type           w;
      logic [32:0]        r0;
      logic [32:0]        r1;
      logic [LamBits-1:0] q0;
      logic [LamBits-1:0] q1;
   } div_type;

   typedef struct packed {
      logic               cand;
      logic signed [31:0] p0x, p0y, p1x, p1y;
      logic signed [49:0] m0x, m0y, m1x, m1y;
   } mul_type;

   function automatic logic [33+LamBits-1:0] div_step(logic [32:0] r, logic [LamBits-1:0] q,
                                                     logic [32:0] den);
      logic [33:0] t, s;
      t = {r, 1'b0};
      s = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
         return {s[32:0], q[LamBits-2:0], 1'b1};
      end
      return {t[32:0], q[LamBits-2:0], 1'b0};
   endfunction

   function automatic logic [LamBits-1:0] fix_lam(edge_type e, logic [LamBits-1:0] q);
      if (e.zero) begin
         return '0;
      end
      if (e.sat) begin
         return '1;
      end
      return q;
   endfunction

   function automatic logic signed [31:0] finish(logic signed [31:0] p,
                                                logic signed [49:0] m);
      logic signed [33:0] f, s;
      f = 34'(m >>> LamBits);
      s = f + 34'(p);
      return s[31:0];
   endfunction

   logic    vld_ff [LamBits+2];
   div_type div_ff [LamBits+1];
   div_type div_in [LamBits+1];
   mul_type mul_ff, mul_in;
   logic [LamBits-1:0] lam0, lam1;
   rsp_type res;

   always_comb begin
      div_in[0] = '{w: in_data, r0: in_data.e0.num, r1: in_data.e1.num, q0: '0, q1: '0};
      for (int k = 0; k < LamBits; k++) begin
         div_in[k+1] = div_ff[k];
         {div_in[k+1].r0, div_in[k+1].q0} = div_step(div_ff[k].r0, div_ff[k].q0,
                                                      div_ff[k].w.e0.den);
         {div_in[k+1].r1, div_in[k+1].q1} = div_step(div_ff[k].r1, div_ff[k].q1,
                                                      div_ff[k].w.e1.den);
      end
   end

   always_comb begin
      lam0 = fix_lam(div_ff[LamBits].w.e0, div_ff[LamBits].q0);
      lam1 = fix_lam(div_ff[LamBits].w.e1, div_ff[LamBits].q1);
      mul_in.cand = div_ff[LamBits].w.cand;
      mul_in.p0x  = div_ff[LamBits].w.e0.px;
      mul_in.p0y  = div_ff[LamBits].w.e0.py;
      mul_in.p1x  = div_ff[LamBits].w.e1.px;
      mul_in.p1y  = div_ff[LamBits].w.e1.py;
      mul_in.m0x  = div_ff[LamBits].w.e0.dx * $signed({1'b0, lam0});
      mul_in.m0y  = div_ff[LamBits].w.e0.dy * $signed({1'b0, lam0});
      mul_in.m1x  = div_ff[LamBits].w.e1.dx * $signed({1'b0, lam1});
      mul_in.m1y  = div_ff[LamBits].w.e1.dy * $signed({1'b0, lam1});
   end

   always_comb begin
      res.start_x = finish(mul_ff.p0x, mul_ff.m0x);
      res.start_y = finish(mul_ff.p0y, mul_ff.m0y);
      res.end_x   = finish(mul_ff.p1x, mul_ff.m1x);
      res.end_y   = finish(mul_ff.p1y, mul_ff.m1y);
      res.hit     = mul_ff.cand &&
                    !((res.start_x == res.end_x) && (res.start_y == res.end_y));
      out_data    = res;
      if (!res.hit) begin
         out_data = '0;
      end
   end

   assign out_valid = vld_ff[LamBits+1];

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LamBits; k++) begin
         div_ff[k] <= div_in[k];
      end
      mul_ff <= mul_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LamBits + 2; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < LamBits + 2; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end
endmodule

// File: sv/tpsu_checker.sv
// ----------------------------------------------------------------------------
// tpsu_checker
// Port level checks for the triangle plane slice unit.
// ----------------------------------------------------------------------------
module tpsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input tpsu_pkg::req_type req_data,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input tpsu_pkg::rsp_type rsp_data
);
   import tpsu_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.hit) |->
      (rsp_data.start_x == 0 && rsp_data.start_y == 0 &&
       rsp_data.end_x == 0 && rsp_data.end_y == 0))
      else $error("miss with nonzero coordinates");

   a_hit_distinct: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.hit) |->
      (rsp_data.start_x != rsp_data.end_x || rsp_data.start_y != rsp_data.end_y))
      else $error("hit with degenerate segment");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");
endmodule

bind triangle_plane_slice_unit tpsu_checker u_tpsu_checker (.*);

// File: sim/tb_triangle_plane_slice_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_plane_slice_unit
// Feeds triangles to the slice unit under varied push and pop pressure and
// compares every segment with a fixed-point predictor, in request order.
// ----------------------------------------------------------------------------
module tb_triangle_plane_slice_unit;
   import tpsu_pkg::*;

   class slice_scoreboard;
      rsp_type segment_queue[$];
      int      error_count = 0;

      // floor of p / 65536
      function automatic longint floor_q16(longint p);
         return p >>> 16;
      endfunction

      function automatic void edge_point(longint px, longint py, longint pz,
                                         longint qx, longint qy, longint qz,
                                         longint h, output longint ox,
                                         output longint oy);
         longint n;
         longint d;
         longint lam;
         n = h - pz;
         d = qz - pz;
         if (n < 0) n = -n;
         if (d < 0) d = -d;
         lam = 0;
         if (d != 0) lam = (n << 16) / d;
         if (lam > 65535) lam = 65535;
         ox = px + floor_q16((qx - px) * lam);
         oy = py + floor_q16((qy - py) * lam);
      endfunction

      function automatic rsp_type slice(req_type r);
         longint  v[3][3];
         longint  h;
         int      s[3];
         int      lo;
         int      f1;
         int      f2;
         bit      on_plane;
         longint  sx, sy, ex, ey;
         rsp_type o;
         v[0][0] = r.ax; v[0][1] = r.ay;       v[0][2] = r.az;
         v[1][0] = r.bx; v[1][1] = r.by_coord; v[1][2] = r.bz;
         v[2][0] = r.cx; v[2][1] = r.cy;       v[2][2] = r.cz;
         h = r.plane_z;
         o = '0;
         for (int i = 0; i < 3; i++)
            s[i] = (v[i][2] > h) ? 1 : ((v[i][2] < h) ? -1 : 0);
         if (s[0] >= 0 && s[1] >= 0 && s[2] >= 0) return o;
         if (s[0] <= 0 && s[1] <= 0 && s[2] <= 0) return o;
         on_plane = 0;
         if (s[0] != 0 && s[0] == s[1]) begin
            lo = 2; f1 = 0; f2 = 1;
         end else if (s[1] != 0 && s[1] == s[2]) begin
            lo = 0; f1 = 1; f2 = 2;
         end else if (s[0] != 0 && s[0] == s[2]) begin
            lo = 1; f1 = 0; f2 = 2;
         end else begin
            on_plane = 1;
            if (s[0] == 0) begin
               lo = 0; f1 = 1; f2 = 2;
            end else if (s[1] == 0) begin
               lo = 1; f1 = 0; f2 = 2;
            end else begin
               lo = 2; f1 = 1; f2 = 0;
            end
         end
         if (on_plane) begin
            sx = v[lo][0];
            sy = v[lo][1];
            edge_point(v[f1][0], v[f1][1], v[f1][2], v[f2][0], v[f2][1], v[f2][2],
                       h, ex, ey);
         end else begin
            edge_point(v[lo][0], v[lo][1], v[lo][2], v[f1][0], v[f1][1], v[f1][2],
                       h, sx, sy);
            edge_point(v[lo][0], v[lo][1], v[lo][2], v[f2][0], v[f2][1], v[f2][2],
                       h, ex, ey);
         end
         if (sx == ex && sy == ey) return o;
         o.hit = 1'b1;
         o.start_x = sx[31:0];
         o.start_y = sy[31:0];
         o.end_x = ex[31:0];
         o.end_y = ey[31:0];
         return o;
      endfunction

      function void note_request(req_type r);
         segment_queue = {segment_queue, slice(r)};
      endfunction

      function void check_segment(rsp_type got);
         rsp_type want;
         if (segment_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
            return;
         end
         want = segment_queue.pop_front();
         if (got.hit !== want.hit)
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
         if (got.start_x !== want.start_x)
            $display("%0t: start_x expected %h actual %h", $time, want.start_x, got.start_x);
         if (got.start_y !== want.start_y)
            $display("%0t: start_y expected %h actual %h", $time, want.start_y, got.start_y);
         if (got.end_x !== want.end_x)
            $display("%0t: end_x expected %h actual %h", $time, want.end_x, got.end_x);
         if (got.end_y !== want.end_y)
            $display("%0t: end_y expected %h actual %h", $time, want.end_y, got.end_y);
         if (got !== want) error_count++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_push = 0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 0;
   rsp_type rsp_data;

   slice_scoreboard board = new();
   int  push_idle_pct = 0;
   int  pop_stall_pct = 0;
   bit  pop_hold = 0;

   triangle_plane_slice_unit i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_segment(rsp_data);
   end

   always @(negedge clock) begin
      rsp_pop <= !reset && !pop_hold && ($urandom_range(99) >= pop_stall_pct);
   end

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom;
         default: return $signed($urandom_range(2000)) - 1000 <<< 12;
      endcase
   endfunction

   function automatic req_type random_triangle();
      req_type r;
      r.ax = pick_coord(); r.ay = pick_coord();
      r.bx = pick_coord(); r.by_coord = pick_coord();
      r.cx = pick_coord(); r.cy = pick_coord();
      r.plane_z = pick_coord();
      r.az = pick_coord(); r.bz = pick_coord(); r.cz = pick_coord();
      // mostly straddling triangles, some on the plane
      if ($urandom_range(9) < 7) begin
         r.plane_z = $signed($urandom_range(2000)) - 1000 <<< 12;
         r.az = r.plane_z + ($signed($urandom_range(2000)) - 1000 <<< $urandom_range(12, 17));
         r.bz = r.plane_z - ($signed($urandom_range(2000)) - 1000 <<< $urandom_range(12, 17));
         r.cz = ($urandom_range(3) == 0) ? r.plane_z :
                r.plane_z + ($signed($urandom_range(2000)) - 1000 <<< 13);
      end
      return r;
   endfunction

   // called at a falling edge; leaves push high so requests can go back to back
   task automatic send_triangle(req_type r);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_push <= 1'b0;
      while (board.segment_queue.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (40) @(negedge clock);
   endtask

   function automatic req_type tri_at(int az, int bz, int cz, int h);
      req_type r;
      r.ax = 32'sh0001_0000; r.ay = 32'sh0002_0000; r.az = az;
      r.bx = 32'sh0005_0000; r.by_coord = -32'sh0003_0000; r.bz = bz;
      r.cx = -32'sh0004_0000; r.cy = 32'sh0007_8000; r.cz = cz;
      r.plane_z = h;
      return r;
   endfunction

   initial begin
      req_type r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: no hit above and below, each lone vertex, each on-plane vertex
      send_triangle(tri_at(10, 20, 30, 5));
      send_triangle(tri_at(1, 2, 3, 5));
      send_triangle(tri_at(5, 5, 5, 5));
      send_triangle(tri_at(5, 9, 9, 5));
      send_triangle(tri_at(-10, -10, 99, 0));
      send_triangle(tri_at(99, -10, -10, 0));
      send_triangle(tri_at(-10, 99, -10, 0));
      send_triangle(tri_at(0, 50, -50, 0));
      send_triangle(tri_at(50, 0, -50, 0));
      send_triangle(tri_at(50, -50, 0, 0));
      send_triangle(tri_at(32'sh8000_0000, 32'sh7fff_ffff, 0, 1));
      send_triangle(tri_at(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, -1));
      // degenerate segment: two vertices on the plane at one point
      r = tri_at(0, 0, 7, 0);
      r.bx = r.ax; r.by_coord = r.ay;
      send_triangle(r);
      r = '1; send_triangle(r);
      r = '0; r.az = 32'sh8000_0000; r.bx = 32'sh7fff_ffff; r.cy = 32'sh8000_0000;
      r.cz = 32'sh7fff_ffff; send_triangle(r);
      for (int phase = 0; phase < 4; phase++) begin
         push_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 62 : 21) : 0;
         pop_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 62 : 21) : 0;
         if (phase == 0) begin
            // long receiver hold-off so the queue fills and push backs up
            fork
               begin
                  pop_hold = 1;
                  repeat (120) @(negedge clock);
                  pop_hold = 0;
               end
            join_none
         end
         for (int k = 0; k < 175; k++) send_triangle(random_triangle());
         drain();
      end
      if (board.error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

// File: triangle_plane_slice_unit.f
sv/tpsu_pkg.sv
sv/tpsu_fifo.sv
sv/tpsu_front.sv
sv/tpsu_back.sv
sv/triangle_plane_slice_unit.sv
sv/tpsu_checker.sv
sim/tb_triangle_plane_slice_unit.sv
